### rtl/core/ppst_pkg.sv
// Shared constants, codes and interface structs of the parallel port slave transfer block.
package ppst_pkg;

	localparam int BUF_BYTES = 1024;
	localparam int BUF_AW    = $clog2(BUF_BYTES);
	localparam int WORD_CAP  = BUF_BYTES / 2;
	localparam int LIMIT_W   = $clog2(WORD_CAP + 1);
	localparam int IDX_W     = 11;
	localparam logic [7:0] IDLE_BYTE = 8'hff;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_SELECT = 2'd1,
		KIND_BUF_WR = 2'd2,
		KIND_BUF_RD = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_POLL      = 4'd0,
		OP_ACTION    = 4'd1,
		OP_END       = 4'd2,
		OP_SEND_WORD = 4'd3,
		OP_RECV_WORD = 4'd4,
		OP_SEND_LONG = 4'd5,
		OP_RECV_LONG = 4'd6,
		OP_RECV_BLK  = 4'd7,
		OP_SEND_BLK  = 4'd8,
		OP_ACK_LOW   = 4'd9,
		OP_ACK_HIGH  = 4'd10
	} op_t;

	// Buffer access issued on an accepted word.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	// Result of one accepted word; the two mem flags pick the buffer read data.
	typedef struct packed {
		logic [7:0]  bus_out;
		logic        bus_driven;
		logic        ready_line;
		logic        ack_line;
		logic        busy;
		logic        done;
		logic [31:0] value;
		logic [15:0] size;
		logic [15:0] channel;
		logic        too_large;
		logic        ob_mem;
		logic        val_mem;
	} res_t;

endpackage

### rtl/core/ppst_buf.sv
// Block buffer: single port synchronous memory with a registered read.
module ppst_buf
	import ppst_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output logic [7:0] rdata
);

	logic [7:0] mem [BUF_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/ppst_ctrl.sv
// Handshake sequencer: operation state, byte stepping and buffer access requests.
module ppst_ctrl
	import ppst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  kind,
	input  logic [3:0]  op,
	input  logic [31:0] send_value,
	input  logic [9:0]  block_words,
	input  logic [15:0] channel_in,
	input  logic        select_level,
	input  logic [7:0]  bus_in,
	input  logic [9:0]  buf_addr,
	input  logic [7:0]  buf_data,
	input  logic [7:0]  mem_rd,
	output mem_req_t    req,
	output res_t        res
);

	op_t                active_q;
	logic [IDX_W-1:0]   idx_q;
	logic               await_q;
	logic [31:0]        shift_q;
	logic [15:0]        hsize_q;
	logic [15:0]        hchan_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [7:0]         out_byte_q;
	logic               ob_mem_q;
	logic               drive_q;
	logic               ready_q;
	logic               ack_q;

	op_t                n_active;
	logic [IDX_W-1:0]   n_idx;
	logic               n_await;
	logic [31:0]        n_shift;
	logic [15:0]        n_hsize;
	logic [15:0]        n_hchan;
	logic [LIMIT_W-1:0] n_limit;
	logic [7:0]         n_ob;
	logic               n_obm;
	logic               n_drive;
	logic               n_ready;
	logic               n_ack;
	logic               step;
	logic               fin;
	logic [2:0]         nb;
	logic [2:0]         k;
	logic [31:0]        sel32;
	logic [17:0]        i18;
	logic [17:0]        twice;
	logic [IDX_W-1:0]   a_rx;
	logic [IDX_W-1:0]   a_tx;
	logic [LIMIT_W-1:0] sat;
	mem_req_t           r;
	res_t               o;

	always_comb begin
		n_active = active_q;
		n_idx    = idx_q;
		n_await  = await_q;
		n_shift  = shift_q;
		n_hsize  = hsize_q;
		n_hchan  = hchan_q;
		n_limit  = limit_q;
		n_ob     = ob_mem_q ? mem_rd : out_byte_q;
		n_obm    = 1'b0;
		n_drive  = drive_q;
		n_ready  = ready_q;
		n_ack    = ack_q;
		step     = 1'b0;
		fin      = 1'b0;
		nb       = 3'd2;
		k        = 3'd0;
		sel32    = 32'd0;
		i18      = 18'd0;
		twice    = 18'd0;
		a_rx     = '0;
		a_tx     = '0;
		sat      = (block_words > 10'(WORD_CAP)) ? LIMIT_W'(WORD_CAP)
			: LIMIT_W'(block_words);
		r        = '0;
		o        = '0;

		unique case (kind_t'(kind))
			KIND_START: begin
				if (active_q == OP_POLL) begin
					unique case (op_t'(op))
						OP_POLL: begin
							o.value = select_level ? {24'd0, IDLE_BYTE} : {24'd0, bus_in};
							o.done  = 1'b1;
						end
						OP_ACTION: begin
							n_ready = 1'b0;
							o.done  = 1'b1;
						end
						OP_ACK_LOW: begin
							n_ack  = 1'b0;
							o.done = 1'b1;
						end
						OP_ACK_HIGH: begin
							n_ack  = 1'b1;
							o.done = 1'b1;
						end
						OP_END, OP_SEND_WORD, OP_RECV_WORD, OP_SEND_LONG,
						OP_RECV_LONG, OP_RECV_BLK, OP_SEND_BLK: begin
							n_active = op_t'(op);
							n_idx    = '0;
							n_await  = 1'b1;
							if (op_t'(op) != OP_END) begin
								n_ready = 1'b0;
							end
							if (op_t'(op) == OP_SEND_WORD) begin
								n_shift = {16'd0, send_value[15:0]};
							end else if (op_t'(op) == OP_SEND_LONG) begin
								n_shift = send_value;
							end else begin
								n_shift = 32'd0;
							end
							if (op_t'(op) == OP_RECV_BLK) begin
								n_limit = sat;
							end
							if (op_t'(op) == OP_SEND_BLK) begin
								n_hsize = 16'(sat);
								n_hchan = channel_in;
							end
							step = select_level;
						end
						default: begin
						end
					endcase
				end
			end
			KIND_SELECT: begin
				step = (active_q != OP_POLL) && (select_level == await_q);
			end
			KIND_BUF_WR: begin
				r.we    = 1'b1;
				r.addr  = buf_addr[BUF_AW-1:0];
				r.wdata = buf_data;
			end
			KIND_BUF_RD: begin
				r.re      = 1'b1;
				r.addr    = buf_addr[BUF_AW-1:0];
				o.val_mem = 1'b1;
			end
			default: begin
			end
		endcase

		// One awaited select level: move one byte of the active operation.
		if (step) begin
			i18   = {{(18-IDX_W){1'b0}}, n_idx};
			twice = {1'b0, n_hsize, 1'b0};
			a_rx  = n_idx - IDX_W'(4);
			a_tx  = n_idx - IDX_W'(5);
			unique case (n_active)
				OP_SEND_WORD, OP_SEND_LONG: begin
					nb = (n_active == OP_SEND_WORD) ? 3'd2 : 3'd4;
					if (n_idx == '0) begin
						n_drive = 1'b1;
					end else if (n_idx <= IDX_W'(nb)) begin
						k     = nb - n_idx[2:0];
						sel32 = n_shift >> {k, 3'b000};
						n_ob  = sel32[7:0];
					end else begin
						n_drive = 1'b0;
						fin     = 1'b1;
					end
				end
				OP_RECV_WORD, OP_RECV_LONG: begin
					nb      = (n_active == OP_RECV_WORD) ? 3'd2 : 3'd4;
					n_shift = {n_shift[23:0], bus_in};
					if (n_idx + IDX_W'(1) >= IDX_W'(nb)) begin
						o.value = n_shift;
						fin     = 1'b1;
					end
				end
				OP_RECV_BLK: begin
					if (n_idx == IDX_W'(0)) begin
						n_hchan = {bus_in, 8'd0};
					end else if (n_idx == IDX_W'(1)) begin
						n_hchan = {n_hchan[15:8], bus_in};
					end else if (n_idx == IDX_W'(2)) begin
						n_hsize = {bus_in, 8'd0};
					end else if (n_idx == IDX_W'(3)) begin
						n_hsize   = {n_hsize[15:8], bus_in};
						o.size    = n_hsize;
						o.channel = n_hchan;
						if (n_hsize > 16'(n_limit)) begin
							n_ready     = 1'b1;
							o.too_large = 1'b1;
							fin         = 1'b1;
						end else if (n_hsize == 16'd0) begin
							fin = 1'b1;
						end
					end else begin
						r.we    = 1'b1;
						r.addr  = a_rx[BUF_AW-1:0];
						r.wdata = bus_in;
						// Last byte once the count of data bytes reaches twice the size word.
						if (i18 - 18'd3 >= twice) begin
							o.size    = n_hsize;
							o.channel = n_hchan;
							fin       = 1'b1;
						end
					end
				end
				OP_SEND_BLK: begin
					if (n_idx == IDX_W'(0)) begin
						n_drive = 1'b1;
					end else if (n_idx == IDX_W'(1)) begin
						n_ob = n_hchan[15:8];
					end else if (n_idx == IDX_W'(2)) begin
						n_ob = n_hchan[7:0];
					end else if (n_idx == IDX_W'(3)) begin
						n_ob = n_hsize[15:8];
					end else if (n_idx == IDX_W'(4)) begin
						n_ob = n_hsize[7:0];
					end else if (i18 < twice + 18'd5) begin
						// The byte comes from the buffer's registered read port in the cycle after the request.
						r.re   = 1'b1;
						r.addr = a_tx[BUF_AW-1:0];
						n_obm  = 1'b1;
					end else begin
						n_drive = 1'b0;
						fin     = 1'b1;
					end
				end
				default: begin
					n_ready = 1'b1;
					fin     = 1'b1;
				end
			endcase
			if (fin) begin
				n_active = OP_POLL;
				n_idx    = '0;
				n_await  = 1'b1;
				o.done   = 1'b1;
			end else begin
				n_idx   = n_idx + IDX_W'(1);
				n_await = ~n_idx[0];
			end
		end

		o.bus_out    = n_ob;
		o.ob_mem     = n_obm;
		o.bus_driven = n_drive;
		o.ready_line = n_ready;
		o.ack_line   = n_ack;
		o.busy       = (n_active != OP_POLL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= OP_POLL;
			idx_q      <= '0;
			await_q    <= 1'b1;
			shift_q    <= '0;
			hsize_q    <= '0;
			hchan_q    <= '0;
			limit_q    <= '0;
			out_byte_q <= IDLE_BYTE;
			ob_mem_q   <= 1'b0;
			drive_q    <= 1'b0;
			ready_q    <= 1'b1;
			ack_q      <= 1'b1;
		end else if (accept) begin
			active_q   <= n_active;
			idx_q      <= n_idx;
			await_q    <= n_await;
			shift_q    <= n_shift;
			hsize_q    <= n_hsize;
			hchan_q    <= n_hchan;
			limit_q    <= n_limit;
			out_byte_q <= n_ob;
			ob_mem_q   <= n_obm;
			drive_q    <= n_drive;
			ready_q    <= n_ready;
			ack_q      <= n_ack;
		end
	end

	always_comb begin
		req    = r;
		req.we = r.we & accept;
		req.re = r.re & accept;
		res    = o;
	end

endmodule

### rtl/core/parallel_port_slave_transfer.sv
// Top level of the parallel port slave transfer block.
//
// The input channel (in_valid/in_ready) takes one word per cycle: a firmware
// command, a change of the host select line, or a firmware buffer write or
// read. Every accepted word yields exactly one result word on the output
// channel (out_valid/out_ready) with the bus, ready and ack line levels, the
// busy and done flags and any received value or block header.
// The result of a word accepted at one edge is shown from the next cycle
// on, taken from an output register. Buffer bytes come from the block
// buffer's registered read port in that same cycle. The block takes one
// word per cycle while the output is not stalled; the single port of the
// buffer and the sequencer state are both updated once per accepted word.
// While the receiver stalls, the output register holds its word and the
// block keeps taking input only if that word is taken in the same cycle.
// Reset puts the lines at ready high, ack high, bus released with 0xff
// latched, and no operation active. Buffer contents are undefined until
// written.
module parallel_port_slave_transfer
	import ppst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  op,
	input  logic [31:0] send_value,
	input  logic [9:0]  block_words,
	input  logic [15:0] channel_in,
	input  logic        select_level,
	input  logic [7:0]  bus_in,
	input  logic [9:0]  buf_addr,
	input  logic [7:0]  buf_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  bus_out,
	output logic        bus_driven,
	output logic        ready_line,
	output logic        ack_line,
	output logic        busy_res,
	output logic        done_res,
	output logic [31:0] result_value,
	output logic [15:0] result_size,
	output logic [15:0] result_channel,
	output logic        too_large
);

	logic       accept;
	logic       valid_s1;
	res_t       res;
	res_t       res_s1;
	mem_req_t   req;
	logic [7:0] mem_rd;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	ppst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.kind         (kind),
		.op           (op),
		.send_value   (send_value),
		.block_words  (block_words),
		.channel_in   (channel_in),
		.select_level (select_level),
		.bus_in       (bus_in),
		.buf_addr     (buf_addr),
		.buf_data     (buf_data),
		.mem_rd       (mem_rd),
		.req          (req),
		.res          (res)
	);

	ppst_buf u_buf (
		.clk   (clk),
		.req   (req),
		.rdata (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// The read port only moves on an accepted word, so it holds during a stall.
	assign out_valid      = valid_s1;
	assign bus_out        = res_s1.ob_mem ? mem_rd : res_s1.bus_out;
	assign bus_driven     = res_s1.bus_driven;
	assign ready_line     = res_s1.ready_line;
	assign ack_line       = res_s1.ack_line;
	assign busy_res       = res_s1.busy;
	assign done_res       = res_s1.done;
	assign result_value   = res_s1.val_mem ? {24'd0, mem_rd} : res_s1.value;
	assign result_size    = res_s1.size;
	assign result_channel = res_s1.channel;
	assign too_large      = res_s1.too_large;

endmodule

### test/parallel_port_slave_transfer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the parallel port slave transfer block with host and firmware stimulus.
module parallel_port_slave_transfer_test;
	import ppst_pkg::*;

	localparam int TOTAL_WORDS = 1750;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 48;
	localparam int MAX_REPORTS = 100;

	typedef struct {
		kind_t       kind;
		logic [3:0]  op;
		logic [31:0] send_value;
		logic [9:0]  block_words;
		logic [15:0] channel_in;
		logic        select_level;
		logic [7:0]  bus_in;
		logic [9:0]  buf_addr;
		logic [7:0]  buf_data;
	} port_word_t;

	typedef struct {
		logic [7:0]  bus_out;
		logic        bus_driven;
		logic        ready_line;
		logic        ack_line;
		logic        busy;
		logic        done;
		logic [31:0] value;
		logic [15:0] size;
		logic [15:0] channel;
		logic        too_large;
	} line_state_t;

	// Tracks the device side of the port and the line states it owes the host.
	class handshake_tracker;
		bit          running;
		op_t         run_op = OP_POLL;
		bit [10:0]   step_idx;
		bit          wait_level = 1'b1;
		bit [31:0]   shifter;
		bit [15:0]   hdr_size;
		bit [15:0]   hdr_chan;
		bit [9:0]    limit_words;
		bit [7:0]    bus_byte = IDLE_BYTE;
		bit          drive;
		bit          ready_lvl = 1'b1;
		bit          ack_lvl = 1'b1;
		bit [7:0]    mem [BUF_BYTES];
		bit          filled [BUF_BYTES];
		int          filled_addrs [$];
		line_state_t due_results [$];
		line_state_t pend;
		int          n_errors;
		int          n_checked;
		int          n_ops;
		int          n_steps;

		function bit [9:0] cap_words(bit [9:0] w);
			return (w > WORD_CAP) ? 10'(WORD_CAP) : w;
		endfunction

		function void store_byte(int a, bit [7:0] d);
			mem[a] = d;
			if (!filled[a]) begin
				filled[a] = 1'b1;
				filled_addrs.push_back(a);
			end
		endfunction

		// Number of buffer bytes from address zero up that hold known data.
		function int filled_prefix();
			int n;
			n = 0;
			while (n < BUF_BYTES && filled[n])
				n++;
			return n;
		endfunction

		// The awaited select level has arrived with bus byte b.
		function void step_level(bit [7:0] b);
			int unsigned i;
			int unsigned n;
			bit last;
			i = step_idx;
			last = 1'b0;
			n_steps++;
			case (run_op)
				OP_END: begin
					ready_lvl = 1'b1;
					last = 1'b1;
				end
				OP_SEND_WORD, OP_SEND_LONG: begin
					n = (run_op == OP_SEND_WORD) ? 2 : 4;
					if (i == 0)
						drive = 1'b1;
					else if (i <= n)
						bus_byte = 8'(shifter >> (8 * (n - i)));
					else begin
						drive = 1'b0;
						last = 1'b1;
					end
				end
				OP_RECV_WORD, OP_RECV_LONG: begin
					n = (run_op == OP_RECV_WORD) ? 2 : 4;
					shifter = {shifter[23:0], b};
					if (i + 1 >= n) begin
						pend.value = shifter;
						last = 1'b1;
					end
				end
				OP_RECV_BLK: begin
					if (i == 0)
						hdr_chan = {b, 8'h00};
					else if (i == 1)
						hdr_chan[7:0] = b;
					else if (i == 2)
						hdr_size = {b, 8'h00};
					else if (i == 3) begin
						// The header is reported as soon as it is complete.
						hdr_size[7:0] = b;
						pend.size = hdr_size;
						pend.channel = hdr_chan;
						if (hdr_size > limit_words) begin
							ready_lvl = 1'b1;
							pend.too_large = 1'b1;
							last = 1'b1;
						end else if (hdr_size == 0)
							last = 1'b1;
					end else begin
						if (i - 4 < BUF_BYTES)
							store_byte(i - 4, b);
						if (i - 3 >= 2 * hdr_size) begin
							pend.size = hdr_size;
							pend.channel = hdr_chan;
							last = 1'b1;
						end
					end
				end
				OP_SEND_BLK: begin
					if (i == 0)
						drive = 1'b1;
					else if (i == 1)
						bus_byte = hdr_chan[15:8];
					else if (i == 2)
						bus_byte = hdr_chan[7:0];
					else if (i == 3)
						bus_byte = hdr_size[15:8];
					else if (i == 4)
						bus_byte = hdr_size[7:0];
					else if (i < 5 + 2 * hdr_size)
						bus_byte = (i - 5 < BUF_BYTES) ? mem[i - 5] : 8'h00;
					else begin
						drive = 1'b0;
						last = 1'b1;
					end
				end
				default: last = 1'b1;
			endcase
			if (last) begin
				running = 1'b0;
				step_idx = '0;
				wait_level = 1'b1;
				pend.done = 1'b1;
			end else begin
				step_idx = 11'(i + 1);
				wait_level = ~step_idx[0];
			end
		endfunction

		function void note_word(port_word_t w);
			pend = '{default: '0};
			case (w.kind)
				KIND_START: begin
					if (!running) begin
						n_ops++;
						if (w.op == OP_POLL) begin
							pend.value = w.select_level ? 32'(IDLE_BYTE) : 32'(w.bus_in);
							pend.done = 1'b1;
						end else if (w.op == OP_ACTION) begin
							ready_lvl = 1'b0;
							pend.done = 1'b1;
						end else if (w.op == OP_ACK_LOW) begin
							ack_lvl = 1'b0;
							pend.done = 1'b1;
						end else if (w.op == OP_ACK_HIGH) begin
							ack_lvl = 1'b1;
							pend.done = 1'b1;
						end else if (w.op >= OP_END && w.op <= OP_SEND_BLK) begin
							running = 1'b1;
							run_op = op_t'(w.op);
							step_idx = '0;
							wait_level = 1'b1;
							if (w.op != OP_END)
								ready_lvl = 1'b0;
							if (w.op == OP_SEND_WORD)
								shifter = {16'h0000, w.send_value[15:0]};
							else if (w.op == OP_SEND_LONG)
								shifter = w.send_value;
							else
								shifter = '0;
							if (w.op == OP_RECV_BLK)
								limit_words = cap_words(w.block_words);
							if (w.op == OP_SEND_BLK) begin
								hdr_size = 16'(cap_words(w.block_words));
								hdr_chan = w.channel_in;
							end
							// A select line already at the awaited level counts at once.
							if (w.select_level)
								step_level(w.bus_in);
						end
					end
				end
				KIND_SELECT:
					if (running && w.select_level == wait_level)
						step_level(w.bus_in);
				KIND_BUF_WR: store_byte(w.buf_addr, w.buf_data);
				default: pend.value = 32'(mem[w.buf_addr]);
			endcase
			pend.bus_out = bus_byte;
			pend.bus_driven = drive;
			pend.ready_line = ready_lvl;
			pend.ack_line = ack_lvl;
			pend.busy = running;
			due_results.push_back(pend);
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				// Keep the log readable when the block is badly off.
				if (n_errors < MAX_REPORTS)
					$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				n_errors++;
			end
		endfunction

		function void check_result(line_state_t got);
			line_state_t want;
			n_checked++;
			if (due_results.size() == 0) begin
				$error("result word arrived with nothing outstanding");
				n_errors++;
				return;
			end
			want = due_results.pop_front();
			cmp_field("bus_out", want.bus_out, got.bus_out);
			cmp_field("bus_driven", want.bus_driven, got.bus_driven);
			cmp_field("ready_line", want.ready_line, got.ready_line);
			cmp_field("ack_line", want.ack_line, got.ack_line);
			cmp_field("busy_res", want.busy, got.busy);
			cmp_field("done_res", want.done, got.done);
			cmp_field("result_value", want.value, got.value);
			cmp_field("result_size", want.size, got.size);
			cmp_field("result_channel", want.channel, got.channel);
			cmp_field("too_large", want.too_large, got.too_large);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [3:0]  op;
	logic [31:0] send_value;
	logic [9:0]  block_words;
	logic [15:0] channel_in;
	logic        select_level;
	logic [7:0]  bus_in;
	logic [9:0]  buf_addr;
	logic [7:0]  buf_data;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  bus_out;
	logic        bus_driven;
	logic        ready_line;
	logic        ack_line;
	logic        busy_res;
	logic        done_res;
	logic [31:0] result_value;
	logic [15:0] result_size;
	logic [15:0] result_channel;
	logic        too_large;

	handshake_tracker tracker;
	int n_sent;
	int stall_count;
	int n_holds;
	bit quiet;
	bit hold_req;

	parallel_port_slave_transfer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.op            (op),
		.send_value    (send_value),
		.block_words   (block_words),
		.channel_in    (channel_in),
		.select_level  (select_level),
		.bus_in        (bus_in),
		.buf_addr      (buf_addr),
		.buf_data      (buf_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bus_out       (bus_out),
		.bus_driven    (bus_driven),
		.ready_line    (ready_line),
		.ack_line      (ack_line),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.result_value  (result_value),
		.result_size   (result_size),
		.result_channel(result_channel),
		.too_large     (too_large)
	);

	always #5 clk = ~clk;

	function automatic port_word_t random_word();
		port_word_t w;
		w.kind = kind_t'($urandom_range(0, 3));
		w.op = 4'($urandom);
		w.send_value = $urandom;
		w.block_words = 10'($urandom);
		w.channel_in = 16'($urandom);
		w.select_level = 1'($urandom);
		w.bus_in = 8'($urandom);
		w.buf_addr = 10'($urandom);
		w.buf_data = 8'($urandom);
		return w;
	endfunction

	// Offers one word at a falling edge and returns at the falling edge after
	// it is taken, sometimes after an idle burst.
	task automatic push_word(port_word_t w);
		in_valid <= 1'b1;
		kind <= w.kind;
		op <= w.op;
		send_value <= w.send_value;
		block_words <= w.block_words;
		channel_in <= w.channel_in;
		select_level <= w.select_level;
		bus_in <= w.bus_in;
		buf_addr <= w.buf_addr;
		buf_data <= w.buf_data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.note_word(w);
		n_sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(negedge clk);
		end
	endtask

	task automatic fw_op(logic [3:0] o, logic [31:0] value, logic [9:0] words,
			logic [15:0] chan, logic lvl, logic [7:0] b);
		port_word_t w;
		w = random_word();
		w.kind = KIND_START;
		w.op = o;
		w.send_value = value;
		w.block_words = words;
		w.channel_in = chan;
		w.select_level = lvl;
		w.bus_in = b;
		push_word(w);
	endtask

	task automatic host_step(logic lvl, logic [7:0] b);
		port_word_t w;
		w = random_word();
		w.kind = KIND_SELECT;
		w.select_level = lvl;
		w.bus_in = b;
		push_word(w);
	endtask

	task automatic buf_access(kind_t k, logic [9:0] a, logic [7:0] d);
		port_word_t w;
		w = random_word();
		w.kind = k;
		w.buf_addr = a;
		w.buf_data = d;
		push_word(w);
	endtask

	// Acts as the host until the running operation finishes. hdr holds the
	// channel and size words that a block receive is to get.
	task automatic serve_host(logic [31:0] hdr, bit noisy);
		port_word_t w;
		logic [7:0] b;
		while (tracker.running) begin
			if (noisy && $urandom_range(0, 9) == 0) begin
				// Stray words in the middle of a transfer must not disturb it.
				w = random_word();
				case ($urandom_range(0, 3))
					0: begin
						w.kind = KIND_SELECT;
						w.select_level = ~tracker.wait_level;
					end
					1: w.kind = KIND_START;
					2: w.kind = KIND_BUF_WR;
					default: begin
						w.kind = KIND_SELECT;
						w.select_level = ~tracker.wait_level;
						if (tracker.filled_addrs.size() != 0) begin
							w.kind = KIND_BUF_RD;
							w.buf_addr = 10'(tracker.filled_addrs[
								$urandom_range(0, tracker.filled_addrs.size() - 1)]);
						end
					end
				endcase
				push_word(w);
			end else begin
				b = 8'($urandom);
				if (tracker.run_op == OP_RECV_BLK && tracker.step_idx < 4)
					b = hdr[31 - 8 * tracker.step_idx -: 8];
				host_step(tracker.wait_level, b);
			end
		end
	endtask

	task automatic transfer(logic [3:0] o, logic [31:0] value, logic [9:0] words,
			logic [15:0] chan, logic lvl, logic [31:0] hdr, bit noisy);
		logic [7:0] b0;
		b0 = (o == OP_RECV_BLK) ? hdr[31:24] : 8'($urandom);
		fw_op(o, value, words, chan, lvl, b0);
		serve_host(hdr, noisy);
	endtask

	task automatic directed_part();
		fw_op(OP_POLL, '0, '0, '0, 1'b1, 8'h00);
		fw_op(OP_POLL, '0, '0, '0, 1'b0, 8'h5a);
		fw_op(OP_POLL, '0, '0, '0, 1'b0, 8'hff);
		fw_op(OP_POLL, '0, '0, '0, 1'b0, 8'h00);
		host_step(1'b1, 8'h11);
		fw_op(OP_ACK_LOW, '0, '0, '0, 1'b0, 8'h00);
		fw_op(OP_ACK_HIGH, '0, '0, '0, 1'b0, 8'h00);
		fw_op(OP_ACTION, '0, '0, '0, 1'b0, 8'h00);
		transfer(OP_END, '0, '0, '0, 1'b1, '0, 1'b0);
		transfer(OP_END, '0, '0, '0, 1'b0, '0, 1'b0);
		fw_op(4'(OP_ACK_HIGH + 1), '1, '1, '1, 1'b1, 8'hff);
		fw_op(4'hf, '1, '1, '1, 1'b1, 8'hff);
		buf_access(KIND_BUF_WR, 10'd0, 8'h00);
		buf_access(KIND_BUF_WR, 10'h3ff, 8'hff);
		buf_access(KIND_BUF_RD, 10'd0, 8'h00);
		buf_access(KIND_BUF_RD, 10'h3ff, 8'h00);
		transfer(OP_SEND_WORD, 32'hffff_ffff, '0, '0, 1'b1, '0, 1'b0);
		// A start and a repeated level while busy are both ignored.
		fw_op(OP_RECV_WORD, '0, '0, '0, 1'b0, 8'h00);
		fw_op(OP_POLL, '0, '0, '0, 1'b0, 8'h33);
		host_step(1'b0, 8'h44);
		serve_host('0, 1'b0);
		transfer(OP_SEND_LONG, 32'hffff_ffff, '0, '0, 1'b0, '0, 1'b0);
		transfer(OP_SEND_LONG, 32'h0000_0000, '0, '0, 1'b1, '0, 1'b0);
		transfer(OP_RECV_LONG, '0, '0, '0, 1'b1, '0, 1'b0);
		transfer(OP_RECV_BLK, '0, 10'h3ff, '0, 1'b1, {16'hffff, 16'd2}, 1'b0);
		transfer(OP_RECV_BLK, '0, 10'd4, '0, 1'b0, {16'h0000, 16'd0}, 1'b0);
		transfer(OP_RECV_BLK, '0, 10'd3, '0, 1'b0, {16'h1234, 16'd4}, 1'b0);
		transfer(OP_RECV_BLK, '0, 10'd0, '0, 1'b1, {16'h8001, 16'hffff}, 1'b0);
		// The size limit saturates, so one word past the buffer is refused.
		transfer(OP_RECV_BLK, '0, 10'h3ff, '0, 1'b1, {16'h00a5, 16'(WORD_CAP + 1)}, 1'b0);
		transfer(OP_SEND_BLK, '0, 10'd0, 16'hffff, 1'b1, '0, 1'b0);
		transfer(OP_SEND_BLK, '0, 10'd2, 16'h0000, 1'b0, '0, 1'b0);
	endtask

	task automatic random_part();
		int rand_base;
		int pick;
		int cap;
		bit held;
		logic [9:0] words;
		logic [15:0] size;
		logic [15:0] chan;
		logic [3:0] o;
		rand_base = n_sent;
		held = 1'b0;
		while (n_sent < TOTAL_WORDS) begin
			quiet = (n_sent > TOTAL_WORDS - 150);
			if (!held && n_sent - rand_base > 300) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				o = 4'(OP_SEND_WORD + $urandom_range(0, 3));
				transfer(o, $urandom, 10'($urandom), 16'($urandom), 1'($urandom),
					$urandom, 1'b1);
			end else if (pick < 55) begin
				words = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 8));
				cap = (words > WORD_CAP) ? WORD_CAP : words;
				case ($urandom_range(0, 9))
					0: size = '0;
					1, 2: size = 16'(cap + 1 + $urandom_range(0, 65534 - cap));
					default: size = 16'($urandom_range(0, (cap < 6) ? cap : 6));
				endcase
				chan = 16'($urandom);
				transfer(OP_RECV_BLK, $urandom, words, 16'($urandom), 1'($urandom),
					{chan, size}, 1'b1);
			end else if (pick < 70) begin
				cap = tracker.filled_prefix() / 2;
				words = 10'($urandom_range(0, (cap < 6) ? cap : 6));
				transfer(OP_SEND_BLK, $urandom, words, 16'($urandom), 1'($urandom),
					'0, 1'b1);
			end else if (pick < 82) begin
				case ($urandom_range(0, 5))
					0: o = OP_POLL;
					1: o = OP_ACTION;
					2: o = OP_END;
					3: o = OP_ACK_LOW;
					4: o = OP_ACK_HIGH;
					default: o = 4'(OP_ACK_HIGH + $urandom_range(1, 5));
				endcase
				transfer(o, $urandom, 10'($urandom), 16'($urandom), 1'($urandom),
					$urandom, 1'b1);
			end else if (pick < 92)
				buf_access(KIND_BUF_WR, 10'($urandom), 8'($urandom));
			else if (pick < 97 && tracker.filled_addrs.size() != 0)
				buf_access(KIND_BUF_RD, 10'(tracker.filled_addrs[
					$urandom_range(0, tracker.filled_addrs.size() - 1)]), 8'($urandom));
			else
				host_step(1'($urandom), 8'($urandom));
		end
	endtask

	// Output side: random stalls, plus one long hold-off while input keeps coming.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_req = 1'b0;
				n_holds++;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6))
					@(negedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(line_state_t'{bus_out, bus_driven, ready_line, ack_line,
				busy_res, done_res, result_value, result_size, result_channel, too_large});
	end

	// Ends the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_count = 0;
		else begin
			stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("No word moved for %0d cycles", STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		kind = KIND_START;
		op = OP_POLL;
		send_value = '0;
		block_words = '0;
		channel_in = '0;
		select_level = 1'b0;
		bus_in = '0;
		buf_addr = '0;
		buf_data = '0;
		tracker = new;
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_part();
		random_part();
		in_valid <= 1'b0;
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		$display("Run: %0d words in, %0d results checked, %0d firmware starts, %0d select steps.",
			n_sent, tracker.n_checked, tracker.n_ops, tracker.n_steps);
		$display("Covered all ops, refused, empty and short blocks, %0d hold-off.",
			n_holds);
		if (tracker.n_errors == 0 && tracker.due_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
